FILE: sv/ssmf_pkg.sv
// Package for the scan sliding median filter: fixed widths, reset values,
// sequencer state types and the control structs between the top level and the selector.
// No dependencies; compile first.
`timescale 1ns / 1ps
`default_nettype none

package ssmf_pkg;

    // Fixed field widths
    localparam int CFG_W    = 6;   // filter size register
    localparam int SAMPLE_W = 16;  // range sample in millimetres
    localparam int POS_W    = 12;  // output position field
    localparam int REACH_W  = CFG_W - 1;  // half the filter size
    localparam int LEN_W    = CFG_W + 1;  // window length, up to twice the reach

    localparam logic [CFG_W-1:0] FILTER_SIZE_RST = 6'd10;
    localparam logic [CFG_W-1:0] MIN_FILTER_SIZE = 6'd2;

    // Top level sequencer
    typedef enum logic [2:0] {
        ST_IDLE,   // wait for a sample
        ST_NEXT,   // decide on the next output position
        ST_START,  // launch the median selector
        ST_SEL,    // selector running
        ST_FDAT,   // raw sample read from the ring
        ST_EMIT    // hand the result to the output register
    } t_state;

    // How the current sample's results are produced
    typedef enum logic [1:0] {
        MD_NONE,   // still undecided, nothing to emit
        MD_RAW,    // filter too small, pass the sample through
        MD_FILT,   // window median
        MD_FLUSH   // short scan ended, replay raw samples
    } t_mode;

    // Median selector sequencer
    typedef enum logic [1:0] {
        SS_IDLE,
        SS_PASS,   // stream the window and count zeros at the current bit
        SS_BIT     // settle one result bit
    } t_sel_state;

    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] len;
    } t_sel_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_sel_stat;

endpackage

`default_nettype wire

FILE: sv/ssmf_if.sv
// Channel interfaces for the scan sliding median filter: sample input and result output.
// Depends on ssmf_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ssmf_sample_if;
    import ssmf_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample_value;
    logic                last_sample;

    modport source (output valid, output sample_value, output last_sample, input ready);
    modport sink   (input valid, input sample_value, input last_sample, output ready);
endinterface

interface ssmf_result_if;
    import ssmf_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] filtered_value;
    logic [POS_W-1:0]    position;
    logic                last_result;

    modport source (output valid, output filtered_value, output position,
                    output last_result, input ready);
    modport sink   (input valid, input filtered_value, input position,
                    input last_result, output ready);
endinterface

`default_nettype wire

FILE: sv/ssmf_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ssmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: sv/ssmf_select.sv
// Median selector: radix selection of the element at a given sorted rank, one bit per pass,
// streaming the window from the ring RAM through one shared compare and count unit.
// Depends on ssmf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssmf_select #(
    parameter int RING_DEPTH = 64,
    localparam int IW        = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire ssmf_pkg::t_sel_ctrl           i_ctrl,
    input  wire logic [IW-1:0]                 i_start_idx,
    output logic      [IW-1:0]                 o_raddr,
    input  wire logic [ssmf_pkg::SAMPLE_W-1:0] i_rdata,
    output ssmf_pkg::t_sel_stat                o_stat,
    output logic      [ssmf_pkg::SAMPLE_W-1:0] o_median
);
    import ssmf_pkg::*;

    t_sel_state          r_state, n_state;
    logic                r_vld;
    logic                r_done;
    logic [IW-1:0]       r_addr;
    logic [IW-1:0]       r_start;
    logic [LEN_W-1:0]    r_len;
    logic [LEN_W-1:0]    r_issued;
    logic [LEN_W-1:0]    r_zeros;
    logic [LEN_W-1:0]    r_k;
    logic [SAMPLE_W-1:0] r_prefix;
    logic [SAMPLE_W-1:0] r_hmask;
    logic [SAMPLE_W-1:0] r_bsel;

    logic s_load;
    logic s_issue;
    logic s_count;
    logic s_settle;
    logic s_last_bit;
    logic s_match;
    logic [IW-1:0] s_addr_inc;

    // Element agrees with the prefix on settled bits and has a zero at the current bit
    assign s_match = (((i_rdata ^ r_prefix) & r_hmask) == '0) && ((i_rdata & r_bsel) == '0);
    assign s_addr_inc = (r_addr == IW'(RING_DEPTH - 1)) ? '0 : r_addr + 1'b1;
    assign s_last_bit = r_bsel[0];

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SS_IDLE: begin
                if (i_ctrl.start) n_state = SS_PASS;
            end
            SS_PASS: begin
                if ((r_issued == r_len) && !r_vld) n_state = SS_BIT;
            end
            SS_BIT: begin
                n_state = s_last_bit ? SS_IDLE : SS_PASS;
            end
            default: n_state = SS_IDLE;
        endcase
    end

    // Strobes
    always_comb begin
        s_load   = 1'b0;
        s_issue  = 1'b0;
        s_count  = 1'b0;
        s_settle = 1'b0;
        unique case (r_state)
            SS_IDLE: s_load   = i_ctrl.start;
            SS_PASS: begin
                s_issue = (r_issued != r_len);
                s_count = r_vld && s_match;
            end
            SS_BIT:  s_settle = 1'b1;
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SS_IDLE;
            r_vld   <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_vld   <= s_issue;
            r_done  <= s_settle && s_last_bit;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (s_load) begin
            r_addr   <= i_start_idx;
            r_start  <= i_start_idx;
            r_len    <= i_ctrl.len;
            r_k      <= i_ctrl.len >> 1;
            r_issued <= '0;
            r_zeros  <= '0;
            r_prefix <= '0;
            r_hmask  <= '0;
            r_bsel   <= {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else if (s_settle) begin
            // Rank falls above the zeros: the bit is one
            if (r_k >= r_zeros) begin
                r_prefix <= r_prefix | r_bsel;
                r_k      <= r_k - r_zeros;
            end
            r_hmask  <= r_hmask | r_bsel;
            r_bsel   <= r_bsel >> 1;
            r_zeros  <= '0;
            r_issued <= '0;
            r_addr   <= r_start;
        end else begin
            if (s_issue) begin
                r_addr   <= s_addr_inc;
                r_issued <= r_issued + 1'b1;
            end
            if (s_count) begin
                r_zeros <= r_zeros + 1'b1;
            end
        end
    end

    assign o_raddr     = r_addr;
    assign o_median    = r_prefix;
    assign o_stat.busy = (r_state != SS_IDLE);
    assign o_stat.done = r_done;

endmodule

`default_nettype wire

FILE: sv/scan_sliding_median_filter.sv
// Top level of the scan sliding median filter: scan sequencer, sample ring, output register.
// Depends on ssmf_pkg, ssmf_if, ssmf_ram and ssmf_select.
//
//  channel     | dir | handshake        | payload
//  ------------+-----+------------------+--------------------------------------------
//  i_sample    | in  | valid / ready    | sample_value[15:0], last_sample
//  o_result    | out | valid / ready    | filtered_value[15:0], position[11:0], last_result
//  i_cfg_*     | in  | write enable     | i_cfg_wdata[5:0] = filter size
//
// A sample is taken while the block is idle; the block then works through the results it
// causes and returns to ready. A median result is paced by the selector streaming the
// window (up to 62 samples) once per result bit through the single ring read port.
// Reset is synchronous and needs no clearing pass; the ring is only read where written.
// A stalled output holds its result; the next sample is taken while it waits.
`timescale 1ns / 1ps
`default_nettype none

module scan_sliding_median_filter #(
    parameter int RING_DEPTH      = 64,
    parameter int MAX_SCAN_POINTS = 4096
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    ssmf_sample_if.sink                     i_sample,
    ssmf_result_if.source                   o_result,
    input  wire logic                       i_cfg_we,
    input  wire logic [ssmf_pkg::CFG_W-1:0] i_cfg_wdata
);
    import ssmf_pkg::*;

    localparam int IW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNW = $clog2(MAX_SCAN_POINTS + 1);
    localparam int CW  = (CNW > CFG_W) ? CNW : CFG_W + 1;
    localparam int PW  = (CW > POS_W) ? CW : POS_W;

    // Registers
    t_state              r_state, n_state;
    t_mode               r_mode;
    logic [CFG_W-1:0]    r_filter_size;
    logic [CFG_W-1:0]    r_sfs;
    logic [CW-1:0]       r_cnt;
    logic [CW-1:0]       r_nop;
    logic [CW-1:0]       r_limit;
    logic [IW-1:0]       r_wr_idx;
    logic [IW-1:0]       r_nop_idx;
    logic                r_decided;
    logic                r_last;
    logic [SAMPLE_W-1:0] r_res;
    logic [LEN_W-1:0]    r_len;
    logic [IW-1:0]       r_start_idx;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_value;
    logic [POS_W-1:0]    r_out_pos;
    logic                r_out_last;

    // Strobes
    logic s_accept, s_load_win, s_take_sel, s_take_ram, s_emit, s_finish;

    // Accept-time decisions
    logic [CFG_W-1:0]   sfs_now;
    logic [REACH_W-1:0] a_now;
    logic [CW-1:0]      c_new;
    logic               last_now, small_now, decided_now;
    logic [CW-1:0]      limit_now;
    t_mode              mode_now;

    // Window bounds
    logic [REACH_W-1:0] a_cur;
    logic [CW-1:0]      a_ext;
    logic               i_ge_a;
    logic [CW-1:0]      win_lo, win_hi;
    logic [CW:0]        win_sum;
    logic [IW:0]        idx_diff, idx_wrap;
    logic [IW-1:0]      win_start;
    logic [IW-1:0]      a_mod_tab [2**REACH_W];
    logic               more;
    logic [PW-1:0]      pos_ext;

    // Ring and selector
    logic [IW-1:0]       ram_raddr;
    logic [SAMPLE_W-1:0] ram_rdata;
    t_sel_ctrl           sel_ctrl;
    t_sel_stat           sel_stat;
    logic [IW-1:0]       sel_raddr;
    logic [SAMPLE_W-1:0] sel_median;

    // Reach modulo ring depth, folded at elaboration
    for (genvar k = 0; k < 2**REACH_W; k++) begin : g_amod
        assign a_mod_tab[k] = IW'(k % RING_DEPTH);
    end

    // Decide what this sample produces
    always_comb begin
        sfs_now     = (r_cnt == '0) ? r_filter_size : r_sfs;
        a_now       = sfs_now[CFG_W-1:1];
        c_new       = r_cnt + 1'b1;
        last_now    = i_sample.last_sample || (c_new >= CW'(MAX_SCAN_POINTS));
        small_now   = (sfs_now < MIN_FILTER_SIZE);
        decided_now = r_decided || small_now || (CW'(sfs_now) < c_new);
        if (decided_now && small_now) begin
            mode_now  = MD_RAW;
            limit_now = c_new;
        end else if (decided_now) begin
            mode_now = MD_FILT;
            if (last_now) limit_now = c_new;
            else if (c_new >= CW'(a_now)) limit_now = c_new - CW'(a_now) + 1'b1;
            else limit_now = '0;
        end else if (last_now) begin
            mode_now  = MD_FLUSH;
            limit_now = c_new;
        end else begin
            mode_now  = MD_NONE;
            limit_now = '0;
        end
    end

    // Window of the current position, clipped at the scan ends
    always_comb begin
        a_cur     = r_sfs[CFG_W-1:1];
        a_ext     = CW'(a_cur);
        i_ge_a    = (r_nop >= a_ext);
        win_lo    = i_ge_a ? r_nop - a_ext : '0;
        win_sum   = {1'b0, r_nop} + {1'b0, a_ext};
        win_hi    = (win_sum < {1'b0, r_cnt}) ? win_sum[CW-1:0] : r_cnt;
        idx_diff  = {1'b0, r_nop_idx} - {1'b0, a_mod_tab[a_cur]};
        idx_wrap  = idx_diff[IW] ? idx_diff + (IW+1)'(RING_DEPTH) : idx_diff;
        win_start = i_ge_a ? idx_wrap[IW-1:0] : '0;
        more      = (r_nop < r_limit);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_sample.valid) n_state = ST_NEXT;
            end
            ST_NEXT: begin
                if (!more) begin
                    n_state = ST_IDLE;
                end else begin
                    unique case (r_mode)
                        MD_RAW:   n_state = ST_EMIT;
                        MD_FLUSH: n_state = ST_FDAT;
                        MD_FILT:  n_state = ST_START;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_START: n_state = ST_SEL;
            ST_SEL: begin
                if (sel_stat.done) n_state = ST_EMIT;
            end
            ST_FDAT: n_state = ST_EMIT;
            ST_EMIT: begin
                if (!r_out_valid || o_result.ready) n_state = ST_NEXT;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        i_sample.ready = 1'b0;
        s_accept       = 1'b0;
        s_load_win     = 1'b0;
        s_take_sel     = 1'b0;
        s_take_ram     = 1'b0;
        s_emit         = 1'b0;
        s_finish       = 1'b0;
        sel_ctrl.start = 1'b0;
        sel_ctrl.len   = r_len;
        unique case (r_state)
            ST_IDLE: begin
                i_sample.ready = 1'b1;
                s_accept       = i_sample.valid;
            end
            ST_NEXT: begin
                s_load_win = more && (r_mode == MD_FILT);
                s_finish   = !more && r_last;
            end
            ST_START: sel_ctrl.start = 1'b1;
            ST_SEL:   s_take_sel     = sel_stat.done;
            ST_FDAT:  s_take_ram     = 1'b1;
            ST_EMIT:  s_emit         = !r_out_valid || o_result.ready;
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_mode        <= MD_NONE;
            r_filter_size <= FILTER_SIZE_RST;
            r_sfs         <= '0;
            r_cnt         <= '0;
            r_nop         <= '0;
            r_limit       <= '0;
            r_wr_idx      <= '0;
            r_nop_idx     <= '0;
            r_decided     <= 1'b0;
            r_last        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_filter_size <= i_cfg_wdata;
            end
            // Latch the scan bookkeeping for this sample
            if (s_accept) begin
                r_sfs     <= sfs_now;
                r_cnt     <= c_new;
                r_decided <= decided_now;
                r_last    <= last_now;
                r_mode    <= mode_now;
                r_limit   <= limit_now;
                r_wr_idx  <= (r_wr_idx == IW'(RING_DEPTH - 1)) ? '0 : r_wr_idx + 1'b1;
            end
            // Advance to the next output position
            if (s_emit) begin
                r_nop     <= r_nop + 1'b1;
                r_nop_idx <= (r_nop_idx == IW'(RING_DEPTH - 1)) ? '0 : r_nop_idx + 1'b1;
            end
            // Drop all scan state after the last sample
            if (s_finish) begin
                r_sfs     <= '0;
                r_cnt     <= '0;
                r_nop     <= '0;
                r_limit   <= '0;
                r_wr_idx  <= '0;
                r_nop_idx <= '0;
                r_decided <= 1'b0;
                r_last    <= 1'b0;
                r_mode    <= MD_NONE;
            end
            // Output register valid
            if (s_emit) r_out_valid <= 1'b1;
            else if (o_result.ready) r_out_valid <= 1'b0;
        end
    end

    // Payload registers
    assign pos_ext = PW'(r_nop);
    always_ff @(posedge i_clk) begin
        if (s_accept) r_res <= i_sample.sample_value;
        else if (s_take_sel) r_res <= sel_median;
        else if (s_take_ram) r_res <= ram_rdata;
        if (s_load_win) begin
            r_len       <= LEN_W'(win_hi - win_lo);
            r_start_idx <= win_start;
        end
        if (s_emit) begin
            r_out_value <= r_res;
            r_out_pos   <= pos_ext[POS_W-1:0];
            r_out_last  <= r_last && (r_nop == r_cnt - 1'b1);
        end
    end

    // Sample ring
    assign ram_raddr = sel_stat.busy ? sel_raddr : r_nop_idx;

    ssmf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (s_accept),
        .i_waddr (r_wr_idx),
        .i_wdata (i_sample.sample_value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Window median
    ssmf_select #(
        .RING_DEPTH (RING_DEPTH)
    ) u_select (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (sel_ctrl),
        .i_start_idx (r_start_idx),
        .o_raddr     (sel_raddr),
        .i_rdata     (ram_rdata),
        .o_stat      (sel_stat),
        .o_median    (sel_median)
    );

    assign o_result.valid          = r_out_valid;
    assign o_result.filtered_value = r_out_value;
    assign o_result.position       = r_out_pos;
    assign o_result.last_result    = r_out_last;

endmodule

`default_nettype wire

FILE: sv/ssmf_checker.sv
// Port-level checker for the scan sliding median filter, bound to the top level.
// Depends on ssmf_pkg and scan_sliding_median_filter.
`timescale 1ns / 1ps
`default_nettype none

module ssmf_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          i_in_ready,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [ssmf_pkg::SAMPLE_W-1:0] i_out_value,
    input wire logic [ssmf_pkg::POS_W-1:0]    i_out_pos,
    input wire logic                          i_out_last
);
    import ssmf_pkg::*;

    logic             out_xact;
    logic [POS_W-1:0] r_exp_pos;

    assign out_xact = i_out_valid && i_out_ready;

    // Track the position the next result transaction should carry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_pos <= '0;
        end else if (out_xact) begin
            r_exp_pos <= i_out_last ? '0 : i_out_pos + 1'b1;
        end
    end

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // One sample at a time: busy right after a sample transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready held after sample transaction");

    // Positions run in order within a scan and restart after the last result
    a_position_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xact |-> i_out_pos == r_exp_pos)
        else $error("result position out of order");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_value) && $stable(i_out_pos) && $stable(i_out_last))
        else $error("stalled result changed");

endmodule

bind scan_sliding_median_filter ssmf_checker u_ssmf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample.valid),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_value (o_result.filtered_value),
    .i_out_pos   (o_result.position),
    .i_out_last  (o_result.last_result)
);

`default_nettype wire

FILE: verif/tb_scan_sliding_median_filter.sv
`timescale 1ns / 1ps
// Testbench for scan_sliding_median_filter: feeds scans of range samples, predicts each
// result with its own window-median model and checks the results in order, field by field.
// Depends on ssmf_pkg, ssmf_if and the filter RTL.

module tb_scan_sliding_median_filter;
    import ssmf_pkg::*;

    localparam int RING_DEPTH      = 64;
    localparam int MAX_SCAN_POINTS = 4096;
    localparam int WINDOW_MAX      = 64;
    localparam int RANDOM_ITEMS    = 470;
    localparam int SETTLE_CYCLES   = 1100;    // longer than one full-window median
    localparam int LONG_HOLD       = 4000;    // receiver hold-off, in cycles
    localparam int REPORT_LIMIT    = 100;
    localparam int TIMEOUT_NS      = 12_000_000;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic                last;
    } t_sample;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic [POS_W-1:0]    pos;
        logic                last;
    } t_result;

    typedef enum int { SH_RANDOM, SH_TIES, SH_RISING, SH_FALLING, SH_EXTREME } t_shape;
    typedef enum int { RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC } t_rx_pattern;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [CFG_W-1:0]  i_cfg_wdata = '0;

    ssmf_sample_if smp ();
    ssmf_result_if res ();

    scan_sliding_median_filter #(
        .RING_DEPTH      (RING_DEPTH),
        .MAX_SCAN_POINTS (MAX_SCAN_POINTS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample    (smp),
        .o_result    (res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Filter model state
    logic [SAMPLE_W-1:0] ring_copy [RING_DEPTH];
    int unsigned         scan_fill    = 0;
    int unsigned         next_pos     = 0;
    bit                  window_ready = 1'b0;
    logic [CFG_W-1:0]    scan_size    = '0;
    logic [CFG_W-1:0]    size_reg     = FILTER_SIZE_RST;

    t_sample pending_samples[$];
    t_result expected_results[$];

    // Bookkeeping
    bit          sample_taken    = 1'b0;
    int          mismatches      = 0;
    int          results_checked = 0;
    int          samples_taken   = 0;
    int          scans_done      = 0;
    int          size_lo         = FILTER_SIZE_RST;
    int          size_hi         = FILTER_SIZE_RST;
    int          tx_burst_left   = 0;
    int          tx_gap_left     = 0;
    int          rx_hold_left    = 0;
    int          rx_span_left    = 0;
    int          holds_requested = 0;
    int          holds_served    = 0;
    t_rx_pattern rx_mode         = RX_OPEN;

    // Clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Append one predicted result transaction
    function automatic void add_expected(input logic [SAMPLE_W-1:0] v,
                                         input logic [POS_W-1:0] p,
                                         input logic l);
        t_result r;
        r.value = v;
        r.pos   = p;
        r.last  = l;
        expected_results = {expected_results, r};
    endfunction

    // Upper median of samples lo .. hi-1 of the current scan
    function automatic logic [SAMPLE_W-1:0] upper_median(input int unsigned lo,
                                                         input int unsigned hi);
        logic [SAMPLE_W-1:0] sorted [WINDOW_MAX];
        logic [SAMPLE_W-1:0] v;
        int unsigned         n;
        int unsigned         j;
        int unsigned         k;
        n = 0;
        for (j = lo; j < hi && n < WINDOW_MAX; j++) begin
            v = ring_copy[j % RING_DEPTH];
            k = n;
            while (k > 0 && sorted[k-1] > v) begin
                sorted[k] = sorted[k-1];
                k--;
            end
            sorted[k] = v;
            n++;
        end
        return (n == 0) ? '0 : sorted[n/2];
    endfunction

    // Work out every result that one accepted sample releases
    function automatic void compute_scan_results(input logic [SAMPLE_W-1:0] x,
                                                 input logic lst);
        bit          ends;
        int unsigned c;
        int unsigned reach;
        int unsigned stop;
        int unsigned i;
        int unsigned lo;
        int unsigned hi;
        int unsigned n;
        ends = lst;
        n    = 0;
        if (scan_fill == 0)
            scan_size = size_reg;
        ring_copy[scan_fill % RING_DEPTH] = x;
        scan_fill++;
        c = scan_fill;
        // an overlong scan ends on its own
        if (c >= MAX_SCAN_POINTS)
            ends = 1'b1;
        reach = scan_size / 2;
        if (!window_ready && (scan_size < MIN_FILTER_SIZE || c > scan_size))
            window_ready = 1'b1;

        if (window_ready && scan_size < MIN_FILTER_SIZE) begin
            // pass the raw sample through
            add_expected(x, POS_W'(next_pos), ends);
            next_pos++;
        end else if (window_ready) begin
            // medians trail the input by the reach, flush on the last sample
            stop = ends ? c : ((c >= reach) ? c - reach + 1 : 0);
            for (i = next_pos; i < stop && n < WINDOW_MAX; i++) begin
                lo = (i >= reach) ? i - reach : 0;
                hi = (i + reach < c) ? i + reach : c;
                add_expected(upper_median(lo, hi), POS_W'(i), ends && (i == c - 1));
                n++;
            end
            next_pos = i;
        end else if (ends) begin
            // scan too short for the filter: replay it unchanged
            for (i = next_pos; i < c && n < WINDOW_MAX; i++) begin
                add_expected(ring_copy[i % RING_DEPTH], POS_W'(i), i == c - 1);
                n++;
            end
            next_pos = i;
        end

        if (ends) begin
            scan_fill    = 0;
            next_pos     = 0;
            window_ready = 1'b0;
            scan_size    = '0;
            scans_done++;
        end
    endfunction

    // Predict on accepted samples, check accepted results
    always @(posedge i_clk) begin : check_results
        t_result want;
        sample_taken = i_rst_n && smp.valid && smp.ready;
        if (sample_taken) begin
            compute_scan_results(smp.sample_value, smp.last_sample);
            samples_taken++;
        end
        if (i_rst_n && res.valid && res.ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $error("unexpected result: filtered_value %0d position %0d last_result %0b",
                           res.filtered_value, res.position, res.last_result);
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (res.filtered_value !== want.value) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $error("filtered_value mismatch: expected %0d, actual %0d",
                               want.value, res.filtered_value);
                end
                if (res.position !== want.pos) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $error("position mismatch: expected %0d, actual %0d",
                               want.pos, res.position);
                end
                if (res.last_result !== want.last) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $error("last_result mismatch: expected %0b, actual %0b",
                               want.last, res.last_result);
                end
            end
        end
    end

    // Sample driver: bursts of random length with random gaps
    always @(negedge i_clk) begin : drive_samples
        logic                nv;
        logic [SAMPLE_W-1:0] nval;
        logic                nlast;
        t_sample             s;
        nv    = smp.valid;
        nval  = smp.sample_value;
        nlast = smp.last_sample;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else if (!smp.valid || sample_taken) begin
            nv = 1'b0;
            if (tx_gap_left > 0) begin
                tx_gap_left--;
            end else if (pending_samples.size() > 0) begin
                s     = pending_samples.pop_front();
                nv    = 1'b1;
                nval  = s.value;
                nlast = s.last;
                if (tx_burst_left > 1) begin
                    tx_burst_left--;
                end else begin
                    tx_burst_left = $urandom_range(1, 24);
                    tx_gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
        smp.valid        <= nv;
        smp.sample_value <= nval;
        smp.last_sample  <= nlast;
    end

    // Result receiver: changing stall pattern, plus long hold-offs on request
    always @(negedge i_clk) begin : drive_ready
        logic rdy;
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            rdy = 1'b0;
        end else if (holds_served != holds_requested) begin
            holds_served++;
            rx_hold_left = LONG_HOLD;
            rdy = 1'b0;
        end else begin
            if (rx_span_left == 0) begin
                rx_mode      = t_rx_pattern'($urandom_range(0, 3));
                rx_span_left = $urandom_range(16, 200);
            end else begin
                rx_span_left--;
            end
            case (rx_mode)
                RX_OPEN:   rdy = 1'b1;
                RX_COIN:   rdy = 1'($urandom_range(0, 1));
                RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
                default:   rdy = (rx_span_left % 3) != 0;
            endcase
        end
        res.ready <= rdy;
    end

    task automatic push_sample(input logic [SAMPLE_W-1:0] v, input logic lst);
        t_sample s;
        s.value = v;
        s.last  = lst;
        pending_samples = {pending_samples, s};
    endtask

    // Queue one scan (or a piece of one) with a random value pattern
    task automatic queue_scan(input int len, input bit closed);
        t_shape              shape;
        logic [SAMPLE_W-1:0] base;
        logic [SAMPLE_W-1:0] step;
        logic [SAMPLE_W-1:0] v;
        int                  k;
        shape = t_shape'($urandom_range(0, 4));
        base  = SAMPLE_W'($urandom);
        step  = SAMPLE_W'($urandom_range(0, 400));
        for (k = 0; k < len; k++) begin
            case (shape)
                SH_TIES:    v = {base[SAMPLE_W-1:2], 2'($urandom_range(0, 3))};
                SH_RISING:  v = base + SAMPLE_W'(k) * step;
                SH_FALLING: v = base - SAMPLE_W'(k) * step;
                SH_EXTREME: begin
                    case ($urandom_range(0, 3))
                        0:       v = 16'h0000;
                        1:       v = 16'h0001;
                        2:       v = 16'hFFFE;
                        default: v = 16'hFFFF;
                    endcase
                end
                default:    v = SAMPLE_W'($urandom);
            endcase
            push_sample(v, closed && (k == len - 1));
        end
    endtask

    // Hold the sender until every expected result is out, then let the block settle
    task automatic wait_idle();
        while (pending_samples.size() != 0 || smp.valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_filter_size(input int v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= CFG_W'(v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        size_reg = CFG_W'(v);
        if (v < size_lo) size_lo = v;
        if (v > size_hi) size_hi = v;
    endtask

    // Stimulus
    initial begin : stimulus
        int ph;
        int size;
        int len;
        int pick;
        int phase_items;
        int random_items;
        bit closed;
        smp.valid        = 1'b0;
        smp.sample_value = '0;
        smp.last_sample  = 1'b0;
        res.ready        = 1'b0;
        random_items     = 0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset filter size: extreme values, decision point, flush at the end
        push_sample(16'h0000, 1'b0);
        push_sample(16'hFFFF, 1'b0);
        push_sample(16'h0001, 1'b0);
        push_sample(16'hFFFE, 1'b0);
        push_sample(16'h8000, 1'b0);
        push_sample(16'h7FFF, 1'b0);
        push_sample(16'hAAAA, 1'b0);
        push_sample(16'h5555, 1'b0);
        push_sample(16'h0000, 1'b0);
        push_sample(16'hFFFF, 1'b0);
        push_sample(16'h00FF, 1'b0);
        push_sample(16'hFF00, 1'b1);
        // one-sample scan
        push_sample(16'h1234, 1'b1);
        wait_idle();

        // raw pass-through at both sizes below the minimum
        set_filter_size(0);
        push_sample(16'hFFFF, 1'b0);
        push_sample(16'h0000, 1'b1);
        wait_idle();
        set_filter_size(1);
        push_sample(16'h4321, 1'b1);
        wait_idle();

        // scan exactly as long as the filter: replayed raw
        set_filter_size(3);
        push_sample(16'd300, 1'b0);
        push_sample(16'd200, 1'b0);
        push_sample(16'd100, 1'b1);
        // size written mid-scan only applies from the next scan
        push_sample(16'd900, 1'b0);
        push_sample(16'd50, 1'b0);
        wait_idle();
        set_filter_size(2);
        push_sample(16'd700, 1'b0);
        push_sample(16'd20, 1'b1);
        push_sample(16'd300, 1'b0);
        push_sample(16'd200, 1'b0);
        push_sample(16'd100, 1'b1);
        wait_idle();

        // random phases, one filter size each
        ph = 0;
        while (random_items < RANDOM_ITEMS) begin
            if (ph == 0) begin
                size = 63;
            end else if (ph == 1) begin
                size = 0;
            end else begin
                pick = $urandom_range(0, 19);
                if (pick < 12)      size = $urandom_range(2, 12);
                else if (pick < 15) size = $urandom_range(0, 1);
                else if (pick < 19) size = $urandom_range(13, 30);
                else                size = $urandom_range(31, 63);
            end
            set_filter_size(size);

            phase_items = 0;
            if (size > 12) begin
                // wide windows are slow: one scan around the filter size
                len = (ph == 0) ? size + 1 : $urandom_range(size - 2, size + 4);
                queue_scan(len, 1'b1);
                phase_items = len;
            end else begin
                while (phase_items < 30) begin
                    case ($urandom_range(0, 5))
                        0:       len = $urandom_range(1, 2);
                        1:       len = size;
                        2:       len = size + 1;
                        3:       len = size - 1;
                        default: len = $urandom_range(1, size + 25);
                    endcase
                    if (len < 1)
                        len = 1;
                    // now and then leave the scan open across the size change
                    closed = (phase_items + len < 30) || ($urandom_range(0, 3) != 0);
                    queue_scan(len, closed);
                    phase_items += len;
                end
            end
            random_items += phase_items;

            // stall the receiver long enough to back up the input
            if (ph % 6 == 2)
                holds_requested++;
            wait_idle();
            ph++;
        end

        $display("checked %0d results from %0d samples in %0d scans, filter sizes %0d to %0d,",
                 results_checked, samples_taken, scans_done, size_lo, size_hi);
        $display("with %0d long receiver stalls and the sender drained after every phase",
                 holds_served);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("timeout with %0d results still expected", expected_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
sv/ssmf_pkg.sv
sv/ssmf_if.sv
sv/ssmf_ram.sv
sv/ssmf_select.sv
sv/scan_sliding_median_filter.sv
sv/ssmf_checker.sv
verif/tb_scan_sliding_median_filter.sv
